@@ design/rrts_pkg.sv @@
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types, constants and flag helpers for the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W    = $clog2(NUM_SLOTS);
	localparam int TIME_W    = 48;
	localparam int TS_W      = 20;
	localparam int FLAG_W    = 10;
	localparam int SEM_W     = 16;

	localparam logic [TS_W-1:0] TS_RESET = TS_W'(10000);

	// flag bit positions
	localparam int FB_READY   = 0;
	localparam int FB_BLOCKED = 1;
	localparam int FB_INTR    = 2;
	localparam int FB_INTRD   = 3;
	localparam int FB_TWAIT   = 4;
	localparam int FB_TOUT    = 5;
	localparam int FB_STOP    = 6;
	localparam int FB_DBG     = 7;
	localparam int FB_RUN     = 8;

	typedef logic [FLAG_W-1:0] flags_t;
	typedef logic [SLOT_W-1:0] sidx_t;
	typedef logic [TIME_W-1:0] time_t;

	typedef enum logic [2:0] {
		CMD_SCHED   = 3'd0,
		CMD_CREATE  = 3'd1,
		CMD_REMOVE  = 3'd2,
		CMD_FLAG    = 3'd3,
		CMD_WAIT    = 3'd4,
		CMD_IDLE    = 3'd5,
		CMD_COLLECT = 3'd6,
		CMD_READ    = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		FOP_STOP     = 3'd0,
		FOP_CONT     = 3'd1,
		FOP_DBG_STOP = 3'd2,
		FOP_DBG_GO   = 3'd3,
		FOP_INTR     = 3'd4
	} fop_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_IN_USE  = 2'd1,
		ERR_EMPTY   = 2'd2,
		ERR_DENIED  = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		RSN_OK    = 2'd0,
		RSN_INTR  = 2'd1,
		RSN_TOUT  = 2'd2,
		RSN_NONE  = 2'd3
	} rsn_t;

	// wake check of a task that is not ready: {sem taken, new flags}
	function automatic logic [FLAG_W:0] resume(input flags_t f, input logic sem_b,
			input logic dl_le);
		flags_t r;
		logic   took;
		r    = f;
		took = 1'b0;
		if (!f[FB_READY]) begin
			if (r[FB_BLOCKED] && sem_b) begin
				r[FB_READY]   = 1'b1;
				r[FB_BLOCKED] = 1'b0;
				took          = 1'b1;
			end
			if (r[FB_INTR]) begin
				r[FB_READY] = 1'b1;
				r[FB_INTRD] = 1'b1;
				r[FB_INTR]  = 1'b0;
			end
			if (r[FB_TWAIT] && dl_le) begin
				r[FB_READY] = 1'b1;
				r[FB_TOUT]  = 1'b1;
				r[FB_TWAIT] = 1'b0;
			end
		end
		return {took, r};
	endfunction

	// semaphore bit of a slot; slots past the vector have none
	function automatic logic sem_bit(input logic [SEM_W-1:0] sem, input sidx_t i);
		return (32'(i) < SEM_W) ? sem[4'(i)] : 1'b0;
	endfunction

	// next slot in round-robin order
	function automatic sidx_t next_slot(input sidx_t i);
		return (i == SLOT_W'(NUM_SLOTS - 1)) ? '0 : i + 1'b1;
	endfunction

endpackage

@@ design/rrts_alu.sv @@
// ----------------------------------------------------------------------------
// rrts_alu
// Shared time unit: one 48-bit compare against now and one 48-bit adder.
// ----------------------------------------------------------------------------
module rrts_alu (
	input  rrts_pkg::time_t cmp_a,
	input  rrts_pkg::time_t now,
	input  rrts_pkg::time_t add_b,
	output logic            le_now,
	output rrts_pkg::time_t sum
);
	import rrts_pkg::*;

	// deadline / slice end reached
	assign le_now = (cmp_a <= now);

	// wraps modulo 2^48
	assign sum = now + add_b;

endmodule

@@ design/round_robin_task_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_unit
// Round-robin task scheduler with timeslice over a fixed table of task slots.
// ----------------------------------------------------------------------------
// A word is taken only while the sequencer is idle. Every command but schedule
// passes through accept, execute and response steps. Schedule passes through
// accept, check and response when the running task keeps the CPU; otherwise
// it walks the table: the walk tests one slot per cycle through the single
// shared 48-bit compare unit, then the running task is tested last and the
// winner written back. The next word is taken while the result still waits
// in the output register. No clearing pass after reset.
module round_robin_task_scheduler_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [rrts_pkg::TS_W-1:0]   cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [2:0]                  command,
	input  logic [3:0]                  slot,
	input  logic [2:0]                  flag_op,
	input  logic [rrts_pkg::TIME_W-1:0] now_us,
	input  logic [rrts_pkg::SEM_W-1:0]  sem_ready,
	input  logic                        wait_on_sem,
	input  logic [rrts_pkg::TIME_W-1:0] timeout_us,
	input  logic                        timeout_relative,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [3:0]                  current_slot,
	output logic                        switched,
	output logic                        ran_idle,
	output logic                        semaphore_taken,
	output logic [rrts_pkg::FLAG_W-1:0] slot_flags,
	output logic [1:0]                  wake_reason,
	output logic [1:0]                  error
);
	import rrts_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CHECK = 7'b0000010,
		ST_WALK  = 7'b0000100,
		ST_LAST  = 7'b0001000,
		ST_FIN   = 7'b0010000,
		ST_EXEC  = 7'b0100000,
		ST_RESP  = 7'b1000000
	} state_t;

	state_t st_q;

	// captured input word
	cmd_t              cmd_q;
	logic [3:0]        slot_q;
	logic [2:0]        fop_q;
	time_t             now_q;
	logic [SEM_W-1:0]  sem_q;
	logic              wsem_q;
	time_t             tmo_q;
	logic              rel_q;

	// task table
	logic [NUM_SLOTS-1:0] valid_q;
	logic [NUM_SLOTS-1:0] waits_q;
	flags_t               flags_q [NUM_SLOTS];
	time_t                slice_q [NUM_SLOTS];
	time_t                dl_q    [NUM_SLOTS];
	sidx_t                running_q;
	sidx_t                idle_slot_q;
	logic [TS_W-1:0]      ts_q;

	// walk state and result fields
	sidx_t                idx_q;
	sidx_t                k_q;
	sidx_t                sel_q;
	logic                 sw_q;
	logic                 ran_idle_q;
	logic                 took_q;
	err_t                 err_q;
	rsn_t                 rsn_q;

	// output register
	logic                 out_valid_q;
	logic [3:0]           cur_out_q;
	logic                 sw_out_q;
	logic                 idle_out_q;
	logic                 took_out_q;
	flags_t               flags_out_q;
	rsn_t                 rsn_out_q;
	err_t                 err_out_q;

	// decode of the addressed slot
	sidx_t  sidx;
	logic   slot_ok;
	logic   addressed;
	assign sidx      = SLOT_W'(slot_q);
	assign slot_ok   = (32'(slot_q) < NUM_SLOTS) && valid_q[sidx];
	assign addressed = (cmd_q == CMD_CREATE) || (cmd_q == CMD_REMOVE) ||
		(cmd_q == CMD_FLAG) || (cmd_q == CMD_READ);

	// single flag read port
	sidx_t  fl_raddr;
	flags_t f_rd;
	always_comb begin
		unique case (st_q)
			ST_WALK, ST_LAST: fl_raddr = idx_q;
			ST_FIN:           fl_raddr = sel_q;
			ST_EXEC:          fl_raddr = (cmd_q == CMD_FLAG) ? sidx : running_q;
			ST_RESP:          fl_raddr = addressed ? sidx : running_q;
			default:          fl_raddr = running_q;
		endcase
	end
	assign f_rd = flags_q[fl_raddr];

	// shared compare / add unit
	time_t cmp_a;
	time_t add_b;
	logic  le_now;
	time_t sum;
	assign cmp_a = (st_q == ST_CHECK) ? slice_q[running_q] : dl_q[idx_q];
	assign add_b = (st_q == ST_FIN) ? TIME_W'(ts_q) : tmo_q;

	rrts_alu u_alu (
		.cmp_a  (cmp_a),
		.now    (now_q),
		.add_b  (add_b),
		.le_now (le_now),
		.sum    (sum)
	);

	// wake test of the slot under the walk pointer
	flags_t          f_walk;
	logic [FLAG_W:0] res;
	flags_t          f_res;
	logic            res_took;
	logic            elig;
	assign f_walk   = (st_q == ST_LAST) ? (f_rd & ~(FLAG_W'(1) << FB_RUN)) : f_rd;
	assign res      = resume(f_walk, sem_bit(sem_q, idx_q), le_now);
	assign f_res    = res[FLAG_W-1:0];
	assign res_took = res[FLAG_W];
	assign elig     = valid_q[idx_q] && !f_walk[FB_RUN] && !f_walk[FB_STOP] &&
		!f_walk[FB_DBG];

	// begin wait deadline
	time_t tmo_eff;
	assign tmo_eff = rel_q ? sum : tmo_q;

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (st_q != ST_IDLE);

	// deadline store: written only by begin wait and create
	always_ff @(posedge clk) begin
		if (st_q == ST_EXEC) begin
			if (cmd_q == CMD_WAIT && tmo_eff != '0) begin
				dl_q[running_q] <= tmo_eff;
			end else if (cmd_q == CMD_CREATE && 32'(slot_q) < NUM_SLOTS &&
					!valid_q[sidx]) begin
				dl_q[sidx] <= '0;
			end
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_q  <= cmd_t'(command);
			slot_q <= slot;
			fop_q  <= flag_op;
			now_q  <= now_us;
			sem_q  <= sem_ready;
			wsem_q <= wait_on_sem;
			tmo_q  <= timeout_us;
			rel_q  <= timeout_relative;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q <= TS_RESET;
		end else if (cfg_wr_en) begin
			ts_q <= cfg_wr_data;
		end
	end

	// sequencer and task table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			valid_q     <= NUM_SLOTS'(1);
			waits_q     <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				flags_q[i] <= (i == 0) ? (FLAG_W'(1) << FB_READY) : '0;
				slice_q[i] <= '0;
			end
			running_q   <= '0;
			idle_slot_q <= '0;
			idx_q       <= '0;
			k_q         <= '0;
			sel_q       <= '0;
			sw_q        <= 1'b0;
			ran_idle_q  <= 1'b0;
			took_q      <= 1'b0;
			err_q       <= ERR_NONE;
			rsn_q       <= RSN_NONE;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						sw_q       <= 1'b0;
						ran_idle_q <= 1'b0;
						took_q     <= 1'b0;
						err_q      <= ERR_NONE;
						rsn_q      <= RSN_NONE;
						st_q       <= (cmd_t'(command) == CMD_SCHED) ? ST_CHECK : ST_EXEC;
					end
				end
				ST_CHECK: begin
					// running task keeps the CPU while its slice lasts
					if (f_rd[FB_READY] && !f_rd[FB_STOP] && !f_rd[FB_DBG] && !le_now) begin
						st_q <= ST_RESP;
					end else begin
						idx_q <= next_slot(running_q);
						k_q   <= SLOT_W'(1);
						st_q  <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (elig) begin
						flags_q[idx_q] <= f_res;
						took_q         <= took_q | res_took;
					end
					if (elig && f_res[FB_READY]) begin
						sel_q <= idx_q;
						st_q  <= ST_FIN;
					end else if (k_q == SLOT_W'(NUM_SLOTS - 1)) begin
						idx_q <= running_q;
						st_q  <= ST_LAST;
					end else begin
						idx_q <= next_slot(idx_q);
						k_q   <= k_q + 1'b1;
					end
				end
				ST_LAST: begin
					// running task tested last, idle slot as fallback
					if (elig) begin
						flags_q[idx_q] <= f_res;
						took_q         <= took_q | res_took;
					end
					if (elig && f_res[FB_READY]) begin
						sel_q <= idx_q;
					end else begin
						sel_q      <= idle_slot_q;
						ran_idle_q <= 1'b1;
					end
					st_q <= ST_FIN;
				end
				ST_FIN: begin
					if (sel_q != running_q) begin
						flags_q[running_q][FB_RUN] <= 1'b0;
					end
					flags_q[sel_q]             <= f_rd | (FLAG_W'(1) << FB_RUN);
					slice_q[sel_q]             <= sum;
					sw_q                       <= (sel_q != running_q);
					running_q                  <= sel_q;
					st_q                       <= ST_RESP;
				end
				ST_EXEC: begin
					unique case (cmd_q)
						CMD_CREATE: begin
							if (32'(slot_q) >= NUM_SLOTS) begin
								err_q <= ERR_EMPTY;
							end else if (valid_q[sidx]) begin
								err_q <= ERR_IN_USE;
							end else begin
								valid_q[sidx] <= 1'b1;
								flags_q[sidx] <= FLAG_W'(1) << FB_READY;
								slice_q[sidx] <= '0;
								waits_q[sidx] <= 1'b0;
							end
						end
						CMD_REMOVE: begin
							if (!slot_ok) begin
								err_q <= ERR_EMPTY;
							end else if (sidx == '0 || sidx == running_q ||
									sidx == idle_slot_q) begin
								err_q <= ERR_DENIED;
							end else begin
								valid_q[sidx] <= 1'b0;
								flags_q[sidx] <= '0;
								waits_q[sidx] <= 1'b0;
							end
						end
						CMD_FLAG: begin
							if (!slot_ok) begin
								err_q <= ERR_EMPTY;
							end else begin
								unique case (fop_q)
									FOP_STOP:     flags_q[sidx][FB_STOP] <= 1'b1;
									FOP_CONT:     flags_q[sidx][FB_STOP] <= 1'b0;
									FOP_DBG_STOP: flags_q[sidx][FB_DBG]  <= 1'b1;
									FOP_DBG_GO:   flags_q[sidx][FB_DBG]  <= 1'b0;
									FOP_INTR:     flags_q[sidx][FB_INTR] <= 1'b1;
									default:      err_q <= ERR_DENIED;
								endcase
							end
						end
						CMD_WAIT: begin
							waits_q[running_q]            <= wsem_q;
							flags_q[running_q][FB_READY]  <= 1'b0;
							flags_q[running_q][FB_BLOCKED] <= f_rd[FB_BLOCKED] | wsem_q;
							flags_q[running_q][FB_TWAIT]  <= f_rd[FB_TWAIT] | (tmo_eff != '0);
						end
						CMD_IDLE: begin
							idle_slot_q        <= running_q;
							flags_q[running_q] <= FLAG_W'(1) << FB_STOP;
						end
						CMD_COLLECT: begin
							if (!f_rd[FB_READY]) begin
								err_q <= ERR_DENIED;
							end else begin
								priority if (waits_q[running_q] && !f_rd[FB_BLOCKED]) begin
									rsn_q <= RSN_OK;
								end else if (f_rd[FB_INTRD]) begin
									rsn_q <= RSN_INTR;
								end else if (f_rd[FB_TOUT]) begin
									rsn_q <= RSN_TOUT;
								end else begin
									rsn_q <= RSN_NONE;
								end
								flags_q[running_q][FB_BLOCKED] <= 1'b0;
								flags_q[running_q][FB_TWAIT]   <= 1'b0;
								flags_q[running_q][FB_INTRD]   <= 1'b0;
								flags_q[running_q][FB_TOUT]    <= 1'b0;
								waits_q[running_q]             <= 1'b0;
							end
						end
						CMD_READ: begin
							if (!slot_ok) begin
								err_q <= ERR_EMPTY;
							end
						end
						default: begin
						end
					endcase
					st_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (st_q == ST_RESP && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_RESP && out_free) begin
			cur_out_q   <= 4'(running_q);
			sw_out_q    <= sw_q;
			idle_out_q  <= ran_idle_q;
			took_out_q  <= took_q;
			flags_out_q <= (addressed && !slot_ok) ? '0 : {1'b0, f_rd[FLAG_W-2:0]};
			rsn_out_q   <= rsn_q;
			err_out_q   <= err_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign current_slot    = cur_out_q;
	assign switched        = sw_out_q;
	assign ran_idle        = idle_out_q;
	assign semaphore_taken = took_out_q;
	assign slot_flags      = flags_out_q;
	assign wake_reason     = rsn_out_q;
	assign error           = err_out_q;

	// checks
	a_run_valid: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[running_q])
		else $error("running slot is not a valid slot");

	a_out_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q == ST_RESP))
		else $error("result word without response step");

	a_fin_to_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FIN) |=> (st_q == ST_RESP))
		else $error("schedule write-back not followed by response");

endmodule

@@ tb/sv/round_robin_task_scheduler_unit_tb.sv @@
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_unit_tb
// Drives command words into the task scheduler under several timeslice
// settings and flow-control patterns. A scoreboard keeps its own copy of
// the slot table, predicts each response word and checks it field by field.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rrts_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		cmd_t        cmd;
		logic [3:0]  slot;
		logic [2:0]  op;
		logic [47:0] now;
		logic [15:0] sem;
		logic        wsem;
		logic [47:0] tmo;
		logic        rel;
	} cmd_word_t;

	typedef struct {
		logic [3:0] cur;
		logic       sw;
		logic       idle;
		logic       took;
		flags_t     flags;
		rsn_t       reason;
		err_t       err;
	} rsp_word_t;

	// slot table shadow and response checker
	class sched_scoreboard;
		bit          valid_q[NUM_SLOTS];
		flags_t      tflags[NUM_SLOTS];
		logic [47:0] deadline[NUM_SLOTS];
		logic [47:0] slice_end[NUM_SLOTS];
		bit          sem_wait[NUM_SLOTS];
		int unsigned run_slot;
		int unsigned idle_slot;
		logic [19:0] slice_len;
		rsp_word_t   expected_rsp[$];
		int          mismatches;

		function new();
			for (int i = 0; i < NUM_SLOTS; i++) begin
				valid_q[i] = 0; tflags[i] = '0; deadline[i] = '0;
				slice_end[i] = '0; sem_wait[i] = 0;
			end
			valid_q[0] = 1;
			tflags[0][FB_READY] = 1'b1;
			run_slot = 0;
			idle_slot = 0;
			slice_len = TS_RESET;
			mismatches = 0;
		endfunction

		function int pending();
			return expected_rsp.size();
		endfunction

		// wake check: a not-ready task may become ready
		function void try_wake(int i, logic [15:0] sem, logic [47:0] now, inout bit took);
			flags_t f;
			f = tflags[i];
			if (f[FB_READY]) return;
			if (f[FB_BLOCKED] && sem[i]) begin
				f[FB_READY] = 1; f[FB_BLOCKED] = 0; took = 1;
			end
			if (f[FB_INTR]) begin
				f[FB_READY] = 1; f[FB_INTRD] = 1; f[FB_INTR] = 0;
			end
			if (f[FB_TWAIT] && deadline[i] <= now) begin
				f[FB_READY] = 1; f[FB_TOUT] = 1; f[FB_TWAIT] = 0;
			end
			tflags[i] = f;
		endfunction

		function bit can_take_cpu(int i, logic [15:0] sem, logic [47:0] now, inout bit took);
			if (tflags[i][FB_RUN] || tflags[i][FB_STOP] || tflags[i][FB_DBG]) return 0;
			try_wake(i, sem, now, took);
			return tflags[i][FB_READY];
		endfunction

		// predict the response to an accepted command word
		function void note_word(cmd_word_t w);
			rsp_word_t r;
			int unsigned cur, sel, s;
			bit found, busy, took;
			flags_t cf, add;
			logic [47:0] tmo;
			cur = run_slot;
			s = w.slot;
			took = 0;
			r.sw = 0; r.idle = 0; r.reason = RSN_NONE; r.err = ERR_NONE;
			case (w.cmd)
				CMD_SCHED: begin
					cf = tflags[cur];
					busy = cf[FB_READY] && !cf[FB_STOP] && !cf[FB_DBG] && slice_end[cur] > w.now;
					if (!busy) begin
						found = 0;
						sel = cur;
						for (int k = 1; k < NUM_SLOTS && !found; k++) begin
							int unsigned i;
							i = (cur + k) % NUM_SLOTS;
							if (valid_q[i] && can_take_cpu(i, w.sem, w.now, took)) begin
								sel = i;
								found = 1;
							end
						end
						tflags[cur][FB_RUN] = 0;
						if (!found) begin
							if (valid_q[cur] && can_take_cpu(cur, w.sem, w.now, took)) sel = cur;
							else begin
								sel = idle_slot;
								r.idle = 1;
							end
						end
						tflags[sel][FB_RUN] = 1;
						slice_end[sel] = w.now + 48'(slice_len);
						r.sw = (sel != cur);
						run_slot = sel;
					end
				end
				CMD_CREATE: begin
					if (valid_q[s]) r.err = ERR_IN_USE;
					else begin
						valid_q[s] = 1; tflags[s] = '0; tflags[s][FB_READY] = 1;
						deadline[s] = '0; slice_end[s] = '0; sem_wait[s] = 0;
					end
				end
				CMD_REMOVE: begin
					if (!valid_q[s]) r.err = ERR_EMPTY;
					else if (s == 0 || s == cur || s == idle_slot) r.err = ERR_DENIED;
					else begin
						valid_q[s] = 0; tflags[s] = '0; sem_wait[s] = 0;
					end
				end
				CMD_FLAG: begin
					if (!valid_q[s]) r.err = ERR_EMPTY;
					else if (w.op == FOP_STOP) tflags[s][FB_STOP] = 1;
					else if (w.op == FOP_CONT) tflags[s][FB_STOP] = 0;
					else if (w.op == FOP_DBG_STOP) tflags[s][FB_DBG] = 1;
					else if (w.op == FOP_DBG_GO) tflags[s][FB_DBG] = 0;
					else if (w.op == FOP_INTR) tflags[s][FB_INTR] = 1;
					else r.err = ERR_DENIED;
				end
				CMD_WAIT: begin
					add = '0;
					add[FB_BLOCKED] = w.wsem;
					sem_wait[cur] = w.wsem;
					tmo = w.rel ? w.tmo + w.now : w.tmo;
					if (tmo != 0) begin
						add[FB_TWAIT] = 1;
						deadline[cur] = tmo;
					end
					cf = tflags[cur];
					cf[FB_READY] = 0;
					tflags[cur] = cf | add;
				end
				CMD_IDLE: begin
					idle_slot = cur;
					tflags[cur] = '0;
					tflags[cur][FB_STOP] = 1;
				end
				CMD_COLLECT: begin
					cf = tflags[cur];
					if (!cf[FB_READY]) r.err = ERR_DENIED;
					else begin
						if (sem_wait[cur] && !cf[FB_BLOCKED]) r.reason = RSN_OK;
						else if (cf[FB_INTRD]) r.reason = RSN_INTR;
						else if (cf[FB_TOUT]) r.reason = RSN_TOUT;
						cf[FB_BLOCKED] = 0; cf[FB_TWAIT] = 0; cf[FB_INTRD] = 0; cf[FB_TOUT] = 0;
						tflags[cur] = cf;
						sem_wait[cur] = 0;
					end
				end
				default: begin
					if (!valid_q[s]) r.err = ERR_EMPTY;
				end
			endcase
			if (w.cmd inside {CMD_CREATE, CMD_REMOVE, CMD_FLAG, CMD_READ})
				r.flags = valid_q[s] ? tflags[s] : '0;
			else
				r.flags = tflags[run_slot];
			r.flags[9] = 0;
			r.cur = run_slot[3:0];
			r.took = took;
			expected_rsp.push_back(r);
		endfunction

		task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
			$display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
			mismatches++;
		endtask

		// compare a delivered response word with the oldest prediction
		task check_word(rsp_word_t g);
			rsp_word_t e;
			if (expected_rsp.size() == 0) begin
				report_mismatch("unexpected word, cur", g.cur, 0);
				return;
			end
			e = expected_rsp.pop_front();
			if (g.cur !== e.cur) report_mismatch("current_slot", g.cur, e.cur);
			if (g.sw !== e.sw) report_mismatch("switched", g.sw, e.sw);
			if (g.idle !== e.idle) report_mismatch("ran_idle", g.idle, e.idle);
			if (g.took !== e.took) report_mismatch("semaphore_taken", g.took, e.took);
			if (g.flags !== e.flags) report_mismatch("slot_flags", g.flags, e.flags);
			if (g.reason !== e.reason) report_mismatch("wake_reason", g.reason, e.reason);
			if (g.err !== e.err) report_mismatch("error", g.err, e.err);
		endtask
	endclass

	logic              clk = 0;
	logic              arst_n = 0;
	logic              cfg_wr_en = 0;
	logic [TS_W-1:0]   cfg_wr_data = '0;
	logic              in_valid = 0;
	logic              in_stall;
	logic [2:0]        command = '0;
	logic [3:0]        slot = '0;
	logic [2:0]        flag_op = '0;
	logic [TIME_W-1:0] now_us = '0;
	logic [SEM_W-1:0]  sem_ready = '0;
	logic              wait_on_sem = 0;
	logic [TIME_W-1:0] timeout_us = '0;
	logic              timeout_relative = 0;
	logic              out_valid;
	logic              out_stall = 0;
	logic [3:0]        current_slot;
	logic              switched, ran_idle, semaphore_taken;
	logic [FLAG_W-1:0] slot_flags;
	logic [1:0]        wake_reason, error;

	sched_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int unsigned cycles = 0;
	logic [47:0] sys_now = '0;

	round_robin_task_scheduler_unit uut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall), .command(command), .slot(slot),
		.flag_op(flag_op), .now_us(now_us), .sem_ready(sem_ready),
		.wait_on_sem(wait_on_sem), .timeout_us(timeout_us),
		.timeout_relative(timeout_relative), .out_valid(out_valid), .out_stall(out_stall),
		.current_slot(current_slot), .switched(switched), .ran_idle(ran_idle),
		.semaphore_taken(semaphore_taken), .slot_flags(slot_flags),
		.wake_reason(wake_reason), .error(error)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("round_robin_task_scheduler_unit verification failed");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// accepted command words
	always @(posedge clk) begin
		cmd_word_t w;
		if (arst_n && in_valid && !in_stall) begin
			w.cmd = cmd_t'(command); w.slot = slot; w.op = flag_op; w.now = now_us;
			w.sem = sem_ready; w.wsem = wait_on_sem; w.tmo = timeout_us;
			w.rel = timeout_relative;
			sb.note_word(w);
		end
	end

	// delivered response words
	always @(posedge clk) begin
		rsp_word_t g;
		if (arst_n && out_valid && !out_stall) begin
			g.cur = current_slot; g.sw = switched; g.idle = ran_idle;
			g.took = semaphore_taken; g.flags = slot_flags;
			g.reason = rsn_t'(wake_reason); g.err = err_t'(error);
			sb.check_word(g);
		end
	end

	function automatic logic [47:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	task send_word(cmd_t c, logic [3:0] s, logic [2:0] op, logic [47:0] n,
			logic [15:0] sem, logic ws, logic [47:0] tmo, logic rel);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		command <= c; slot <= s; flag_op <= op; now_us <= n; sem_ready <= sem;
		wait_on_sem <= ws; timeout_us <= tmo; timeout_relative <= rel;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task write_slice(logic [TS_W-1:0] v);
		cfg_wr_en <= 1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 0;
		sb.slice_len = v;
	endtask

	// wait for every response, then let the block settle
	task drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// random word, mostly plausible task life cycles on an advancing clock
	task send_random();
		int pick;
		logic [47:0] tmo;
		logic [15:0] sem;
		cmd_t c;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 49) == 0) sys_now = rand48();
		else sys_now += 48'($urandom_range(0, 2 * int'(sb.slice_len) + 3));
		if (pick < 35) c = CMD_SCHED;
		else if (pick < 47) c = CMD_CREATE;
		else if (pick < 53) c = CMD_REMOVE;
		else if (pick < 68) c = CMD_FLAG;
		else if (pick < 80) c = CMD_WAIT;
		else if (pick < 83) c = CMD_IDLE;
		else if (pick < 93) c = CMD_COLLECT;
		else c = CMD_READ;
		case ($urandom_range(0, 3))
			0: tmo = '0;
			1: tmo = rand48();
			default: tmo = 48'($urandom_range(0, 3 * int'(sb.slice_len) + 5));
		endcase
		sem = ($urandom_range(0, 2) == 0) ? 16'h0 : 16'($urandom);
		send_word(c, 4'($urandom), ($urandom_range(0, 9) == 0) ? 3'($urandom) :
			3'($urandom_range(0, 4)), sys_now, sem, 1'($urandom), tmo,
			($urandom_range(0, 2) != 0));
	endtask

	initial begin
		logic [TS_W-1:0] slice_vals[5];
		int mode_send[5];
		int mode_recv[5];
		slice_vals = '{20'd1, 20'hFFFFF, 20'd0, 20'($urandom_range(1, 1000000)), 20'd1000000};
		mode_send = '{0, 80, 0, 15, 0};
		mode_recv = '{0, 0, 80, 15, 0};

		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: errors, flag ops, waits, wrap-around, idle fallback
		send_word(CMD_READ, 4'd0, FOP_STOP, 48'd0, 16'h0, 0, 48'd0, 0);
		send_word(CMD_READ, 4'd15, FOP_STOP, 48'd0, 16'h0, 0, 48'd0, 0);
		send_word(CMD_CREATE, 4'd15, FOP_STOP, 48'd0, 16'h0, 0, 48'd0, 0);
		send_word(CMD_CREATE, 4'd15, FOP_STOP, 48'd0, 16'h0, 0, 48'd0, 0);
		for (int op = 0; op < 8; op++)
			send_word(CMD_FLAG, 4'd15, 3'(op), 48'd0, 16'h0, 0, 48'd0, 0);
		send_word(CMD_FLAG, 4'd15, FOP_CONT, 48'd0, 16'h0, 0, 48'd0, 0);
		send_word(CMD_FLAG, 4'd3, FOP_INTR, 48'd0, 16'h0, 0, 48'd0, 0);
		send_word(CMD_REMOVE, 4'd0, FOP_STOP, 48'd0, 16'h0, 0, 48'd0, 0);
		send_word(CMD_REMOVE, 4'd3, FOP_STOP, 48'd0, 16'h0, 0, 48'd0, 0);
		send_word(CMD_SCHED, 4'd0, FOP_STOP, 48'd0, 16'hFFFF, 0, 48'd0, 0);
		send_word(CMD_WAIT, 4'd0, FOP_STOP, 48'd5, 16'h0, 1, 48'hFFFF_FFFF_FFFF, 1);
		send_word(CMD_COLLECT, 4'd0, FOP_STOP, 48'd5, 16'h0, 0, 48'd0, 0);
		send_word(CMD_SCHED, 4'd0, FOP_STOP, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 0, 48'd0, 0);
		send_word(CMD_COLLECT, 4'd0, FOP_STOP, 48'd6, 16'h0, 0, 48'd0, 0);
		send_word(CMD_WAIT, 4'd0, FOP_STOP, 48'd7, 16'h0, 0, 48'd0, 0);
		send_word(CMD_SCHED, 4'd0, FOP_STOP, 48'hFFFF_FFFF_FFFF, 16'h0, 0, 48'd0, 0);
		send_word(CMD_IDLE, 4'd0, FOP_STOP, 48'd8, 16'h0, 0, 48'd0, 0);
		send_word(CMD_SCHED, 4'd0, FOP_STOP, 48'hFFFF_FFFF_FFFF, 16'h0, 0, 48'd0, 0);
		drain();

		// random phases, one timeslice setting each
		for (int p = 0; p < 5; p++) begin
			send_idle_pct = mode_send[p];
			recv_stall_pct = mode_recv[p];
			write_slice(slice_vals[p]);
			repeat (130) send_random();
			drain();
		end
		recv_stall_pct = 0;

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("round_robin_task_scheduler_unit verification clean");
		else
			$display("round_robin_task_scheduler_unit verification failed");
		$finish;
	end
endmodule
